// ----- hdl/sdq_pkg.sv -----
// sdq_pkg: shared types, codes and constants of the searchable deque
// used by the interfaces, the cell chain, the controller and the checker
package sdq_pkg;

	localparam int LIST_DEPTH_DEF = 16;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int LEN_W    = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_REM_FRONT = 3'd2,
		OP_REM_BACK  = 3'd3,
		OP_SEARCH    = 3'd4,
		OP_UPDATE    = 3'd5
	} op_t;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_WALK,
		FSM_DONE
	} fsm_t;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic                       load_back;
		logic signed [VALUE_W-1:0]  front_in;
		logic signed [VALUE_W-1:0]  wrap_in;
	} chain_ctrl_t;

endpackage

// ----- hdl/sdq_req_if.sv -----
// sdq_req_if: request channel of the searchable deque
// depends on sdq_pkg for field widths
interface sdq_req_if
	import sdq_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic signed [VALUE_W-1:0] operand_value;
	logic signed [VALUE_W-1:0] replacement_value;

	modport source (output valid, output operation, output operand_value,
		output replacement_value, input ready);
	modport sink (input valid, input operation, input operand_value,
		input replacement_value, output ready);
endinterface

// ----- hdl/sdq_rsp_if.sv -----
// sdq_rsp_if: result channel of the searchable deque
// depends on sdq_pkg for field widths
interface sdq_rsp_if
	import sdq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    match_position;
	logic [LEN_W-1:0]    list_length;

	modport source (output valid, output status, output match_position,
		output list_length, input ready);
	modport sink (input valid, input status, input match_position,
		input list_length, output ready);
endinterface

// ----- hdl/sdq_cell.sv -----
// sdq_cell: one storage cell of the deque chain, holds the entry at one position
// depends on sdq_pkg for the cell operation codes
module sdq_cell
	import sdq_pkg::*;
(
	input  logic                      clk,
	input  cell_op_t                  op,
	input  logic                      load,
	input  logic signed [VALUE_W-1:0] load_val,
	input  logic signed [VALUE_W-1:0] from_left,
	input  logic signed [VALUE_W-1:0] from_right,
	output logic signed [VALUE_W-1:0] value_q
);

	always_ff @(posedge clk) begin
		case (op)
			CELL_FROM_LEFT:  value_q <= from_left;
			CELL_FROM_RIGHT: value_q <= from_right;
			default: begin
				if (load) begin
					value_q <= load_val;
				end
			end
		endcase
	end

endmodule

// ----- hdl/sdq_ctrl.sv -----
// sdq_ctrl: sequencer of the deque, keeps the length, walks the chain for
// search and update, and holds the result register; depends on sdq_pkg
module sdq_ctrl
	import sdq_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF,
	parameter int IW = $clog2(LIST_DEPTH),
	parameter int CW = $clog2(LIST_DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	sdq_req_if.sink                   req,
	sdq_rsp_if.source                 rsp,
	input  logic signed [VALUE_W-1:0] head_val,
	output chain_ctrl_t               chain,
	output logic [CW-1:0]             count
);

	fsm_t                      state_q, state_nxt;
	logic [IW-1:0]             step_q;
	logic [CW-1:0]             count_q, count_nxt;
	logic                      found_q;
	logic [IW-1:0]             pos_q;
	logic                      upd_q;
	logic signed [VALUE_W-1:0] key_q;
	logic signed [VALUE_W-1:0] repl_q;

	logic                      out_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic [POS_W-1:0]          match_q;
	logic [LEN_W-1:0]          len_q;

	logic                      out_free;
	logic                      acc;
	logic                      full;
	logic                      empty;
	logic                      is_find;
	logic                      hit;
	logic                      last_step;
	logic                      rsp_load;
	logic [STATUS_W-1:0]       res_status;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == FSM_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign full      = (count_q == CW'(LIST_DEPTH));
	assign empty     = (count_q == '0);
	assign is_find   = (req.operation == OP_SEARCH) || (req.operation == OP_UPDATE);
	assign last_step = (step_q == IW'(LIST_DEPTH - 1));
	// the entry at position step_q sits in cell 0 during the walk
	assign hit       = (head_val == key_q) && (CW'(step_q) < count_q) && !found_q;
	// a result is loaded right at the request, or after the walk
	assign rsp_load  = ((state_q == FSM_IDLE) && acc && !(is_find && !empty))
		|| ((state_q == FSM_DONE) && out_free);

	assign count          = count_q;
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.match_position = match_q;
	assign rsp.list_length    = len_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (acc && is_find && !empty) begin
					state_nxt = FSM_WALK;
				end
			end
			FSM_WALK: begin
				if (last_step) begin
					state_nxt = FSM_DONE;
				end
			end
			FSM_DONE: begin
				if (out_free) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	// chain control and the results loaded right at the request
	always_comb begin
		chain.op        = CELL_HOLD;
		chain.load_back = 1'b0;
		chain.front_in  = req.operand_value;
		chain.wrap_in   = head_val;
		count_nxt       = count_q;
		res_status      = ST_OK;
		case (state_q)
			FSM_IDLE: begin
				if (acc) begin
					case (req.operation)
						OP_INS_FRONT: begin
							if (full) begin
								res_status = ST_FULL;
							end else begin
								chain.op  = CELL_FROM_LEFT;
								count_nxt = count_q + CW'(1);
							end
						end
						OP_INS_BACK: begin
							if (full) begin
								res_status = ST_FULL;
							end else begin
								chain.load_back = 1'b1;
								count_nxt       = count_q + CW'(1);
							end
						end
						OP_REM_FRONT: begin
							if (empty) begin
								res_status = ST_EMPTY;
							end else begin
								chain.op  = CELL_FROM_RIGHT;
								count_nxt = count_q - CW'(1);
							end
						end
						OP_REM_BACK: begin
							if (empty) begin
								res_status = ST_EMPTY;
							end else begin
								count_nxt = count_q - CW'(1);
							end
						end
						OP_SEARCH, OP_UPDATE: begin
							res_status = ST_NOT_FOUND;
						end
						default: res_status = ST_OK;
					endcase
				end
			end
			FSM_WALK: begin
				// full rotation brings every entry back to its own cell
				chain.op = CELL_FROM_RIGHT;
				if (hit && upd_q) begin
					chain.wrap_in = repl_q;
				end
			end
			default: chain.op = CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				FSM_IDLE: begin
					step_q  <= '0;
					found_q <= 1'b0;
				end
				FSM_WALK: begin
					step_q <= step_q + IW'(1);
					if (hit) begin
						found_q <= 1'b1;
					end
				end
				default: step_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && acc) begin
			key_q    <= req.operand_value;
			repl_q   <= req.replacement_value;
			upd_q    <= (req.operation == OP_UPDATE);
			status_q <= res_status;
			match_q  <= '0;
			len_q    <= LEN_W'(count_nxt);
		end
		if (state_q == FSM_WALK && hit) begin
			pos_q <= step_q;
		end
		if (state_q == FSM_DONE && out_free) begin
			status_q <= found_q ? ST_OK : ST_NOT_FOUND;
			match_q  <= found_q ? POS_W'(pos_q) : '0;
			len_q    <= LEN_W'(count_q);
		end
	end

endmodule

// ----- hdl/searchable_deque.sv -----
// searchable_deque: bounded list of signed 32-bit values with front and back
// insert and remove, search and update of the first match. Entries sit in a
// chain of LIST_DEPTH cells in order from the front, cell 0 holding the front.
// Inserts and removes finish as the request is taken: the chain shifts, one
// cell loads or only the length changes, and the result is shown on the next
// cycle. Search and update rotate the whole chain once through cell 0, one
// position per cycle, then load the result in the DONE state, and no new
// request is taken until the controller is back in idle; that rotation sets
// the worst-case rate. A new request is taken whenever the controller is idle
// and the result register is empty or being read in the same cycle.
module searchable_deque
	import sdq_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sdq_req_if.sink   req,
	sdq_rsp_if.source rsp
);

	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic signed [VALUE_W-1:0] cell_val [LIST_DEPTH];
	chain_ctrl_t               chain;
	logic [CW-1:0]             count;

	sdq_ctrl #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.head_val (cell_val[0]),
		.chain    (chain),
		.count    (count)
	);

	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
		logic signed [VALUE_W-1:0] left_in;
		logic signed [VALUE_W-1:0] right_in;

		if (k == 0) begin : g_first
			assign left_in = chain.front_in;
		end else begin : g_mid_l
			assign left_in = cell_val[k-1];
		end

		// last cell closes the ring back to the front
		if (k == LIST_DEPTH - 1) begin : g_last
			assign right_in = chain.wrap_in;
		end else begin : g_mid_r
			assign right_in = cell_val[k+1];
		end

		sdq_cell u_cell (
			.clk        (clk),
			.op         (chain.op),
			.load       (chain.load_back && (count == CW'(k))),
			.load_val   (chain.front_in),
			.from_left  (left_in),
			.from_right (right_in),
			.value_q    (cell_val[k])
		);
	end

endmodule

// ----- hdl/sdq_checker.sv -----
// sdq_checker: port-level assertions on the searchable deque and the bind
// that attaches them to the top level; depends on sdq_pkg
module sdq_checker
	import sdq_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [POS_W-1:0]    match_position,
	input logic [LEN_W-1:0]    list_length
);

	// a waiting result stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before it was taken");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> list_length == LEN_W'(LIST_DEPTH))
		else $error("full status with list not at capacity");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> list_length == '0)
		else $error("empty status with entries present");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> match_position == '0)
		else $error("match position set on failed request");

endmodule

bind searchable_deque sdq_checker #(
	.LIST_DEPTH(LIST_DEPTH)
) u_sdq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.match_position (rsp.match_position),
	.list_length    (rsp.list_length)
);
